// File: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit.
// Holds action codes, controller states and the command/status structs.
package rau_pkg;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_RED = 4'd4,
    ACT_RCP = 4'd5,
    ACT_INC = 4'd6,
    ACT_DEC = 4'd7,
    ACT_CMP = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_GCD,
    ST_QUO,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic gcd_step;
    logic gcd_end;
    logic div_start;
    logic quo_take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_red;
    logic is_mul;
    logic gcd_done;
    logic gcd_zero;
    logic quo_last;
    logic div_done;
  } sts_t;

endpackage

// File: rtl/core/rational_arithmetic_unit.sv
// Channel | valid     | stall     | payload
// input   | in_valid_i  | in_stall_o  | action_i a_num_i a_den_i b_num_i b_den_i
// output  | out_valid_o | out_stall_i | res_num_o res_den_o is_* fault_o
// Multiplier actions and compare pass through states MUL1, MUL2 and DONE after acceptance;
// reciprocal, increment, decrement and unused codes pass through MUL1 and DONE only.
// Reduce runs Euclid on the bit-serial divider, one divider pass per step, then
// divides both parts by the divisor in two more divider passes.
// Reset is asynchronous and clears only control state.
// A stalled result holds the block; a new item is taken the cycle after it has left.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic        is_less_o,
  output logic        is_equal_o,
  output logic        is_greater_o,
  output logic        fault_o
);

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_num_o, .res_den_o, .is_less_o, .is_equal_o, .is_greater_o, .fault_o
  );

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item taken while result waits");
  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o) else $error("finished result not presented");

endmodule

// File: rtl/core/rau_div.sv
// Iterative unsigned divider for the rational arithmetic unit.
// One quotient bit per cycle; depends on nothing but its parameter.
module rau_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W:0]    trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[W]) begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, Euclid registers and result register. Uses rau_pkg and rau_div.
module rau_datapath import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic        is_less_o,
  output logic        is_equal_o,
  output logic        is_greater_o,
  output logic        fault_o
);

  localparam int PW = 2 * WIDTH;

  logic [3:0]              act_q;
  logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0]    p1_q, p2_q, pd_q;
  logic signed [WIDTH-1:0] x_q, y_q, qn_q, qd_q;
  logic                    phase_q;
  logic [WIDTH-1:0]        dv_a, dv_b, quo, rem;
  logic                    dv_done;
  logic signed [WIDTH-1:0] op1, op2, op3, op4, srem, sq;
  logic signed [PW-1:0]    m1, m2;
  logic [31:0]             rn, rd;
  logic                    lt, eq, gt, flt;

  assign dv_a = x_q[WIDTH-1] ? WIDTH'(-x_q) : x_q;
  assign dv_b = y_q[WIDTH-1] ? WIDTH'(-y_q) : y_q;

  rau_div #(.W(WIDTH)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dv_a),
    .divisor_i (dv_b),
    .done_o    (dv_done),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  assign srem = x_q[WIDTH-1] ? WIDTH'(-rem) : rem;
  assign sq   = (x_q[WIDTH-1] ^ y_q[WIDTH-1]) ? WIDTH'(-quo) : quo;

  always_comb begin
    op1 = an_q; op2 = bd_q; op3 = bn_q; op4 = ad_q;
    if (act_q == ACT_MUL) begin
      op2 = bn_q; op3 = ad_q; op4 = bd_q;
    end else if (act_q == ACT_DIV) begin
      op3 = ad_q; op4 = bn_q;
    end
    if (cmd_i.mul2) begin
      op1 = op3; op2 = op4;
    end
  end
  assign m1 = PW'(op1) * PW'(op2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      an_q  <= a_num_i[WIDTH-1:0];
      ad_q  <= a_den_i[WIDTH-1:0];
      bn_q  <= b_num_i[WIDTH-1:0];
      bd_q  <= b_den_i[WIDTH-1:0];
      x_q   <= a_num_i[WIDTH-1:0];
      y_q   <= a_den_i[WIDTH-1:0];
      phase_q <= 1'b0;
    end
    if (cmd_i.mul1) p1_q <= m1;
    if (cmd_i.mul2) begin
      p2_q <= m1;
      pd_q <= PW'(ad_q) * PW'((act_q == ACT_DIV) ? bn_q : bd_q);
    end
    if (cmd_i.gcd_step && dv_done) begin
      x_q <= y_q;
      y_q <= srem;
    end
    if (cmd_i.gcd_end) begin
      x_q     <= an_q;
      y_q     <= x_q;
      phase_q <= 1'b0;
    end
    if (cmd_i.quo_take) begin
      if (phase_q) begin
        qd_q <= sq;
      end else begin
        qn_q <= sq;
        x_q  <= ad_q;
      end
      phase_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      res_num_o    <= rn;
      res_den_o    <= rd;
      is_less_o    <= lt;
      is_equal_o   <= eq;
      is_greater_o <= gt;
      fault_o      <= flt;
    end
  end

  assign m2 = p1_q - p2_q;

  always_comb begin
    logic signed [WIDTH-1:0] n, d;
    n = '0; d = '0; lt = 1'b0; eq = 1'b0; gt = 1'b0; flt = 1'b0;
    case (act_q)
      ACT_ADD: begin n = WIDTH'(p1_q + p2_q); d = WIDTH'(pd_q); end
      ACT_SUB: begin n = WIDTH'(m2); d = WIDTH'(pd_q); end
      ACT_MUL, ACT_DIV: begin n = WIDTH'(p1_q); d = WIDTH'(pd_q); end
      ACT_RED: begin
        if (y_q == '0) begin
          flt = 1'b1; n = an_q; d = ad_q;
        end else begin
          n = qn_q; d = qd_q;
        end
      end
      ACT_RCP: begin n = ad_q; d = an_q; end
      ACT_INC: begin n = an_q + ad_q; d = ad_q; end
      ACT_DEC: begin n = an_q - ad_q; d = ad_q; end
      ACT_CMP: begin
        lt = p1_q < p2_q; eq = p1_q == p2_q; gt = p1_q > p2_q;
      end
      default: ;
    endcase
    rn = 32'(n);
    rd = 32'(d);
  end

  always_comb begin
    sts_o          = '0;
    sts_o.is_red   = (act_q == ACT_RED);
    sts_o.is_mul   = (act_q == ACT_ADD) || (act_q == ACT_SUB) ||
                     (act_q == ACT_MUL) || (act_q == ACT_DIV) || (act_q == ACT_CMP);
    sts_o.gcd_done = (y_q == '0);
    sts_o.gcd_zero = (x_q == '0);
    sts_o.quo_last = phase_q;
    sts_o.div_done = dv_done;
  end

endmodule

// File: rtl/core/rau_ctrl.sv
// Controller state machine of the rational arithmetic unit.
// Uses rau_pkg; drives the datapath commands and the item handshake.
module rau_ctrl import rau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    ov_d      = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i && !ov_q) state_d = ST_MUL1;
      ST_MUL1: begin
        if (sts_i.is_mul) state_d = ST_MUL2;
        else if (sts_i.is_red) state_d = ST_GCD;
        else state_d = ST_DONE;
        started_d = 1'b0;
      end
      ST_MUL2: state_d = ST_DONE;
      ST_GCD: begin
        if (!started_q) begin
          if (sts_i.gcd_done) state_d = sts_i.gcd_zero ? ST_DONE : ST_QUO;
          else started_d = 1'b1;
        end else if (sts_i.div_done) begin
          started_d = 1'b0;
        end
      end
      ST_QUO: begin
        if (!started_q) started_d = 1'b1;
        else if (sts_i.div_done) begin
          started_d = 1'b0;
          if (sts_i.quo_last) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        ov_d    = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i && !ov_q;
      ST_MUL1: cmd_o.mul1 = 1'b1;
      ST_MUL2: cmd_o.mul2 = 1'b1;
      ST_GCD: begin
        cmd_o.gcd_end   = !started_q && sts_i.gcd_done;
        cmd_o.div_start = !started_q && !sts_i.gcd_done;
        cmd_o.gcd_step  = started_q && sts_i.div_done;
      end
      ST_QUO: begin
        cmd_o.div_start = !started_q;
        cmd_o.quo_take  = started_q && sts_i.div_done;
      end
      ST_DONE: cmd_o.finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE) || ov_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      ov_q      <= ov_d;
    end
  end

endmodule
